// ===== rtl/ofill_pkg.sv =====
`default_nettype none
package ofill_pkg;

    // Sample fields
    localparam int DATA_W = 32;
    // Gap field wide enough for the largest fill limit (1023 missing, gap 1024)
    localparam int GAP_W = 11;
    // Quotient bits of |cur - prev| / gap, one per divider step
    localparam int DIV_STEPS = DATA_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic MODE_NEAREST = 1'b0;
    localparam logic MODE_LINEAR  = 1'b1;

    typedef logic signed [DATA_W-1:0] data_t;

    // One classified sample handed from the front end to the fill engine
    typedef struct packed {
        data_t             cur_idx;
        data_t             cur_val;
        data_t             prev_idx;
        data_t             prev_val;
        logic [GAP_W-1:0]  gap;
        logic              fill;
        logic              too_long;
        logic              mode;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/ofill_front.sv =====
`default_nettype none
module ofill_front #(
    parameter int MAX_FILL = 63
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               fill_mode,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ofill_pkg::data_t   sample_index,
    input  wire ofill_pkg::data_t   sample_value,
    output logic                    cmd_valid,
    input  wire logic               cmd_ready,
    output ofill_pkg::cmd_t         cmd
);
    import ofill_pkg::*;

    localparam logic signed [DATA_W:0] GAP_LIMIT = (DATA_W+1)'(MAX_FILL + 1);
    localparam logic signed [DATA_W:0] GAP_ONE   = (DATA_W+1)'(1);

    logic                     fill_mode_reg;
    logic                     have_prev_reg;
    data_t                    prev_idx_reg;
    data_t                    prev_val_reg;
    logic signed [DATA_W:0]   gap_wide;
    logic                     accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign accept    = in_valid && cmd_ready;

    // Distance from the previous sample, one bit wider so it cannot wrap
    assign gap_wide = {sample_index[DATA_W-1], sample_index}
                    - {prev_idx_reg[DATA_W-1], prev_idx_reg};

    // Classify the beat
    always_comb
    begin
        cmd.cur_idx  = sample_index;
        cmd.cur_val  = sample_value;
        cmd.prev_idx = prev_idx_reg;
        cmd.prev_val = prev_val_reg;
        cmd.gap      = gap_wide[GAP_W-1:0];
        cmd.fill     = have_prev_reg && (gap_wide > GAP_ONE) && (gap_wide <= GAP_LIMIT);
        cmd.too_long = have_prev_reg && (gap_wide > GAP_LIMIT);
        cmd.mode     = fill_mode_reg;
    end

    // Hold mode and the previous sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_mode_reg <= MODE_LINEAR;
            have_prev_reg <= 1'b0;
            prev_idx_reg  <= '0;
            prev_val_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                fill_mode_reg <= fill_mode;
            end
            if (accept)
            begin
                have_prev_reg <= 1'b1;
                prev_idx_reg  <= sample_index;
                prev_val_reg  <= sample_value;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ofill_queue.sv =====
`default_nettype none
module ofill_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire ofill_pkg::cmd_t    push_data,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output ofill_pkg::cmd_t         pop_data
);
    import ofill_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    cmd_t                 mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W:0]       count_reg;
    logic                 push;
    logic                 pop;

    assign push_ready = (count_reg != (PTR_W+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    // Store beats
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ofill_back.sv =====
`default_nettype none
module ofill_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire ofill_pkg::cmd_t    cmd,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ofill_pkg::data_t        out_index,
    output ofill_pkg::data_t        out_value,
    output logic                    is_filled,
    output logic                    gap_too_long,
    output logic                    last_of_run
);
    import ofill_pkg::*;

    localparam int ACC_W  = GAP_W + 2;
    localparam int STEP_W = DATA_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SETUP,
        S_FILL,
        S_PASS
    } state_t;

    state_t                    state_reg, state_next;
    cmd_t                      cmd_reg, cmd_next;
    logic [GAP_W-1:0]          cnt_reg, cnt_next;
    data_t                     fill_idx_reg, fill_idx_next;
    logic                      neg_reg, neg_next;
    logic [DATA_W:0]           dq_reg, dq_next;
    logic [GAP_W-1:0]          rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]      div_cnt_reg, div_cnt_next;
    logic signed [STEP_W-1:0]  step_a_reg, step_a_next;
    logic signed [STEP_W-1:0]  step_b_reg, step_b_next;
    logic [ACC_W-1:0]          acc_r_reg, acc_r_next;
    logic signed [STEP_W-1:0]  val_reg, val_next;
    logic                      out_valid_reg, out_valid_next;
    data_t                     out_index_reg, out_index_next;
    data_t                     out_value_reg, out_value_next;
    logic                      out_filled_reg, out_filled_next;
    logic                      out_long_reg, out_long_next;
    logic                      out_last_reg, out_last_next;

    logic                      can_emit;
    logic signed [DATA_W:0]    diff;
    logic [DATA_W:0]           abs_diff;
    logic [GAP_W-1:0]          missing;
    logic [GAP_W-1:0]          half;
    logic [GAP_W:0]            trial;
    logic                      trial_ge;
    logic [ACC_W-1:0]          r_sum;
    logic [ACC_W-1:0]          two_gap;
    logic                      carry;
    logic signed [STEP_W-1:0]  lin_val;
    logic [STEP_W-1:0]         q_ext;
    logic [STEP_W-1:0]         q1_ext;
    data_t                     fill_val;

    assign can_emit  = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == S_IDLE);

    assign out_valid    = out_valid_reg;
    assign out_index    = out_index_reg;
    assign out_value    = out_value_reg;
    assign is_filled    = out_filled_reg;
    assign gap_too_long = out_long_reg;
    assign last_of_run  = out_last_reg;

    // Difference of the incoming pair, split into sign and magnitude
    assign diff     = {cmd.cur_val[DATA_W-1], cmd.cur_val}
                    - {cmd.prev_val[DATA_W-1], cmd.prev_val};
    assign abs_diff = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;

    assign missing = cmd_reg.gap - GAP_W'(1);
    assign half    = missing >> 1;

    // One restoring divider step
    assign trial    = {rem_reg, dq_reg[DATA_W]};
    assign trial_ge = (trial >= {1'b0, cmd_reg.gap});

    // Remainder walk for the rounded ramp: carry when it reaches twice the gap
    assign r_sum   = acc_r_reg + {1'b0, rem_reg, 1'b0};
    assign two_gap = {1'b0, cmd_reg.gap, 1'b0};
    assign carry   = (r_sum >= two_gap);
    assign lin_val = val_reg + (carry ? step_b_reg : step_a_reg);

    assign q_ext  = {1'b0, dq_reg};
    assign q1_ext = {1'b0, dq_reg} + STEP_W'(1);

    assign fill_val = (cmd_reg.mode == MODE_LINEAR) ? lin_val[DATA_W-1:0]
                    : ((cnt_reg <= half) ? cmd_reg.prev_val : cmd_reg.cur_val);

    // Sequence one command: divide (linear fill only), then fill (any fill), then pass the sample
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        cnt_next        = cnt_reg;
        fill_idx_next   = fill_idx_reg;
        neg_next        = neg_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        step_a_next     = step_a_reg;
        step_b_next     = step_b_reg;
        acc_r_next      = acc_r_reg;
        val_next        = val_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_index_next  = out_index_reg;
        out_value_next  = out_value_reg;
        out_filled_next = out_filled_reg;
        out_long_next   = out_long_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next      = cmd;
                    cnt_next      = GAP_W'(1);
                    fill_idx_next = cmd.prev_idx + DATA_W'(1);
                    neg_next      = diff[DATA_W];
                    dq_next       = abs_diff;
                    rem_next      = '0;
                    div_cnt_next  = '0;
                    if (cmd.fill && (cmd.mode == MODE_LINEAR))
                    begin
                        state_next = S_DIV;
                    end
                    else if (cmd.fill)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        state_next = S_PASS;
                    end
                end
            end
            S_DIV:
            begin
                rem_next     = trial_ge ? GAP_W'(trial - {1'b0, cmd_reg.gap})
                                        : trial[GAP_W-1:0];
                dq_next      = {dq_reg[DATA_W-1:0], trial_ge};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                // Signed per-index steps: quotient, and quotient plus carry
                step_a_next = neg_reg ? -$signed(q_ext) : $signed(q_ext);
                step_b_next = neg_reg ? -$signed(q1_ext) : $signed(q1_ext);
                acc_r_next  = {2'b00, cmd_reg.gap};
                val_next    = STEP_W'(cmd_reg.prev_val);
                state_next  = S_FILL;
            end
            S_FILL:
            begin
                if (can_emit)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = fill_idx_reg;
                    out_value_next  = fill_val;
                    out_filled_next = 1'b1;
                    out_long_next   = 1'b0;
                    out_last_next   = 1'b0;
                    fill_idx_next   = fill_idx_reg + DATA_W'(1);
                    cnt_next        = cnt_reg + GAP_W'(1);
                    val_next        = lin_val;
                    acc_r_next      = carry ? (r_sum - two_gap) : r_sum;
                    if (cnt_reg == missing)
                    begin
                        state_next = S_PASS;
                    end
                end
            end
            S_PASS:
            begin
                if (can_emit)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = cmd_reg.cur_idx;
                    out_value_next  = cmd_reg.cur_val;
                    out_filled_next = 1'b0;
                    out_long_next   = cmd_reg.too_long;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            cnt_reg        <= '0;
            fill_idx_reg   <= '0;
            neg_reg        <= 1'b0;
            dq_reg         <= '0;
            rem_reg        <= '0;
            div_cnt_reg    <= '0;
            step_a_reg     <= '0;
            step_b_reg     <= '0;
            acc_r_reg      <= '0;
            val_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_value_reg  <= '0;
            out_filled_reg <= 1'b0;
            out_long_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            cnt_reg        <= cnt_next;
            fill_idx_reg   <= fill_idx_next;
            neg_reg        <= neg_next;
            dq_reg         <= dq_next;
            rem_reg        <= rem_next;
            div_cnt_reg    <= div_cnt_next;
            step_a_reg     <= step_a_next;
            step_b_reg     <= step_b_next;
            acc_r_reg      <= acc_r_next;
            val_reg        <= val_next;
            out_valid_reg  <= out_valid_next;
            out_index_reg  <= out_index_next;
            out_value_reg  <= out_value_next;
            out_filled_reg <= out_filled_next;
            out_long_reg   <= out_long_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Divider runs only for a linear fill
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cmd_reg.fill && (cmd_reg.mode == MODE_LINEAR)))
        else $error("divider running without a linear fill");

    // Fill counter stays inside the gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (cmd_reg.fill && (cnt_reg >= GAP_W'(1))
                                   && (cnt_reg <= missing)))
        else $error("fill counter outside the gap");

    // A made-up beat never carries the long-gap flag or the end mark
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_filled_reg) |-> (!out_long_reg && !out_last_reg))
        else $error("filled beat flagged as long gap or last");

    // Passing the sample closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_PASS) && can_emit) |=>
            ((state_reg == S_IDLE) && out_valid_reg && out_last_reg && !out_filled_reg))
        else $error("sample beat did not close the run");

endmodule
`default_nettype wire

// ===== rtl/ordered_index_gap_filler_unit.sv =====
// Channel   Direction  Handshake              Beat contents
// cfg       in         cfg_valid/cfg_ready    fill_mode (0 nearest copy, 1 linear)
// in        in         in_valid/in_ready      sample_index, sample_value
// out       out        out_valid/out_ready    out_index, out_value, is_filled,
//                                             gap_too_long, last_of_run
//
// A sample with no fill is popped from the queue into the fill engine, then loaded into the output register.
// A nearest fill emits the made-up samples before the sample; a linear fill first runs the
// bit-serial divide of |cur - prev| by the gap and a setup step, then emits the made-up samples.
// The front end classifies a sample in the cycle it is accepted; a two-entry queue lets it
// run ahead of the fill engine. Reset clears the previous sample and sets linear mode.
// A stalled output register stops the fill engine, the queue then fills and drops in_ready.
`default_nettype none
module ordered_index_gap_filler_unit #(
    parameter int MAX_FILL = 63
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               fill_mode,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ofill_pkg::data_t   sample_index,
    input  wire ofill_pkg::data_t   sample_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ofill_pkg::data_t        out_index,
    output ofill_pkg::data_t        out_value,
    output logic                    is_filled,
    output logic                    gap_too_long,
    output logic                    last_of_run
);
    import ofill_pkg::*;

    cmd_t  front_cmd;
    logic  front_valid;
    logic  front_ready;
    cmd_t  back_cmd;
    logic  back_valid;
    logic  back_ready;

    ofill_front #(
        .MAX_FILL (MAX_FILL)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .fill_mode    (fill_mode),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_index (sample_index),
        .sample_value (sample_value),
        .cmd_valid    (front_valid),
        .cmd_ready    (front_ready),
        .cmd          (front_cmd)
    );

    ofill_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    ofill_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (back_valid),
        .cmd_ready    (back_ready),
        .cmd          (back_cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_index    (out_index),
        .out_value    (out_value),
        .is_filled    (is_filled),
        .gap_too_long (gap_too_long),
        .last_of_run  (last_of_run)
    );

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ofill_pkg::*;

    localparam int FILL_LIMIT = 63;
    // Hold-off of the receiver while the sender keeps offering samples
    localparam int LONG_HOLD = 400;
    // Quiet cycles before a mode write and after the last beat
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        data_t idx;
        data_t val;
        logic  filled;
        logic  too_long;
        logic  last;
    } sample_beat_t;

    // Expected output beats, built from accepted samples in arrival order
    class gap_fill_scoreboard;
        logic         mode;
        bit           have_prev;
        longint       prev_idx;
        longint       prev_val;
        sample_beat_t expected_q[$];
        int           errors;

        function new();
            mode      = MODE_LINEAR;
            have_prev = 1'b0;
            prev_idx  = 0;
            prev_val  = 0;
            errors    = 0;
        endfunction

        function void set_mode(logic m);
            mode = m;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Round num/den to nearest, ties away from zero; den is positive
        function longint round_div(longint num, longint den);
            if (num >= 0)
                return (num * 2 + den) / (den * 2);
            return -(((-num) * 2 + den) / (den * 2));
        endfunction

        function void report_mismatch(string msg);
            errors++;
            if (errors <= 20)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        // Expand one accepted sample into its fill beats and the sample beat
        function void note_sample(data_t s_idx, data_t s_val);
            longint       cur_i;
            longint       cur_v;
            longint       gap;
            longint       missing;
            longint       half;
            longint       v;
            logic         flag;
            sample_beat_t b;
            cur_i = s_idx;
            cur_v = s_val;
            flag  = 1'b0;
            if (have_prev) begin
                gap = cur_i - prev_idx;
                if (gap > 1) begin
                    missing = gap - 1;
                    if (missing > FILL_LIMIT) begin
                        flag = 1'b1;
                    end
                    else begin
                        half = missing / 2;
                        for (longint i = 1; i <= missing; i++) begin
                            if (mode == MODE_NEAREST)
                                v = (i - 1 < half) ? prev_val : cur_v;
                            else
                                v = prev_val + round_div(i * (cur_v - prev_val), gap);
                            b.idx      = data_t'(prev_idx + i);
                            b.val      = data_t'(v);
                            b.filled   = 1'b1;
                            b.too_long = 1'b0;
                            b.last     = 1'b0;
                            expected_q.push_back(b);
                        end
                    end
                end
            end
            b.idx      = s_idx;
            b.val      = s_val;
            b.filled   = 1'b0;
            b.too_long = flag;
            b.last     = 1'b1;
            expected_q.push_back(b);
            have_prev = 1'b1;
            prev_idx  = cur_i;
            prev_val  = cur_v;
        endfunction

        // Compare one output beat with the oldest expectation
        function void check_beat(sample_beat_t got);
            sample_beat_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat index %0d value %0d",
                                          got.idx, got.val));
                return;
            end
            want = expected_q.pop_front();
            if (got.idx !== want.idx)
                report_mismatch($sformatf("out_index %0d, want %0d", got.idx, want.idx));
            if (got.val !== want.val)
                report_mismatch($sformatf("out_value %0d, want %0d at index %0d",
                                          got.val, want.val, want.idx));
            if (got.filled !== want.filled)
                report_mismatch($sformatf("is_filled %b, want %b at index %0d",
                                          got.filled, want.filled, want.idx));
            if (got.too_long !== want.too_long)
                report_mismatch($sformatf("gap_too_long %b, want %b at index %0d",
                                          got.too_long, want.too_long, want.idx));
            if (got.last !== want.last)
                report_mismatch($sformatf("last_of_run %b, want %b at index %0d",
                                          got.last, want.last, want.idx));
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_valid;
    logic  cfg_ready;
    logic  fill_mode;
    logic  in_valid;
    logic  in_ready;
    data_t sample_index;
    data_t sample_value;
    logic  out_valid;
    logic  out_ready;
    data_t out_index;
    data_t out_value;
    logic  is_filled;
    logic  gap_too_long;
    logic  last_of_run;

    gap_fill_scoreboard sb = new();

    // Sender burst bookkeeping and the last sample offered
    int    burst_left;
    data_t last_idx;
    data_t last_val;
    bit    hold_request;

    ordered_index_gap_filler_unit #(
        .MAX_FILL(FILL_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .fill_mode(fill_mode),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample_index(sample_index),
        .sample_value(sample_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_index(out_index),
        .out_value(out_value),
        .is_filled(is_filled),
        .gap_too_long(gap_too_long),
        .last_of_run(last_of_run)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Observe every handshake at the clock edge
    always @(posedge clk)
    begin : beat_monitor
        sample_beat_t seen;
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.set_mode(fill_mode);
            if (out_valid && out_ready) begin
                seen.idx      = out_index;
                seen.val      = out_value;
                seen.filled   = is_filled;
                seen.too_long = gap_too_long;
                seen.last     = last_of_run;
                sb.check_beat(seen);
            end
            if (in_valid && in_ready)
                sb.note_sample(sample_index, sample_value);
        end
    end

    // Offer one sample, opening a new burst after a random gap when due
    task automatic send_sample(input data_t idx, input data_t val);
        int gap_len;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_len = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_len > 0) begin
                in_valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        sample_index <= idx;
        sample_value <= val;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        last_idx = idx;
        last_val = val;
    endtask

    // Drain the block, then write the fill mode
    task automatic write_mode(input logic m);
        in_valid   <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        fill_mode <= m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly ascending indices with short gaps, plus jumps, repeats and long gaps
    task automatic pick_sample(output data_t idx, output data_t val);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3)
            idx = $urandom;
        else if (r < 8)
            idx = last_idx - data_t'($urandom_range(0, 3));
        else if (r < 12)
            idx = last_idx + data_t'($urandom_range(65, 300));
        else if (r < 45)
            idx = last_idx + data_t'(1);
        else if (r < 85)
            idx = last_idx + data_t'($urandom_range(2, 9));
        else
            idx = last_idx + data_t'($urandom_range(10, 64));
        r = $urandom_range(99);
        if (r < 30)
            val = $urandom;
        else if (r < 38)
            val = ($urandom_range(1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        else
            val = last_val + data_t'($urandom_range(2000)) - data_t'(1000);
    endtask

    // Receiver: ready in random patterns, with one long hold on request
    initial
    begin
        int style;
        int span;
        int period;
        out_ready = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            style  = $urandom_range(3);
            span   = $urandom_range(8, 60);
            period = $urandom_range(2, 7);
            for (int c = 0; c < span; c++) begin
                case (style)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(1) != 0);
                    2: out_ready <= ($urandom_range(3) != 0);
                    default: out_ready <= ((c % period) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        data_t idx;
        data_t val;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        fill_mode    = MODE_LINEAR;
        in_valid     = 1'b0;
        sample_index = '0;
        sample_value = '0;
        burst_left   = 0;
        last_idx     = '0;
        last_val     = '0;
        hold_request = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Linear mode out of reset: first sample, ties, full and overlong gaps
        send_sample(32'sd100, 32'sd1000);
        send_sample(32'sd103, 32'sd2000);
        send_sample(32'sd104, -32'sd7);
        send_sample(32'sd104, 32'sd55);
        send_sample(32'sd90, 32'sd12);
        send_sample(32'sd92, 32'sd3);
        send_sample(32'sd94, 32'sd4);
        send_sample(32'sd158, 32'sh8000_0000);
        send_sample(32'sd222, 32'sh7FFF_FFFF);
        send_sample(32'sd287, 32'sd0);
        send_sample(32'sh7FFF_FFFE, -32'sd1);
        send_sample(32'sh7FFF_FFFF, 32'sd1);
        send_sample(32'sh8000_0000, 32'sd5);
        send_sample(32'sh8000_0002, -32'sd5);

        // Nearest mode: odd and even runs, fill limit, overlong gap
        write_mode(MODE_NEAREST);
        send_sample(32'sh8000_0005, 32'sd10);
        send_sample(32'sh8000_0009, 32'sd20);
        send_sample(32'sh8000_0049, 32'sd30);
        send_sample(32'sh8000_008A, 32'sd40);
        send_sample(32'sd0, 32'sh5555_5555);
        send_sample(32'sd2, 32'shAAAA_AAAA);
        send_sample(32'sd5, 32'sh7FFF_FFFF);
        send_sample(32'sd5, 32'sd7);
        send_sample(32'sd3, 32'sd8);
        send_sample(32'sd6, 32'sh8000_0000);

        // Random segments, alternating the fill mode between them
        for (int seg = 0; seg < 4; seg++) begin
            if (seg > 0)
                write_mode((seg % 2 != 0) ? MODE_LINEAR : MODE_NEAREST);
            for (int n = 0; n < 50; n++) begin
                if (seg == 1 && n == 10)
                    hold_request = 1'b1;
                pick_sample(idx, val);
                send_sample(idx, val);
            end
        end

        // Drain, then watch for stray beats
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
